@@ sv/pf_pkg.sv @@
// ----------------------------------------------------------------------------
// pf_pkg
// Shared widths and sequencer states for the prime factoriser.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int VALUE_W = 31;
  localparam int DIV_W   = 16;
  localparam int EXP_W   = 5;
  localparam int CNT_W   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHK,
    ST_DIV,
    ST_EMIT
  } pf_state_t;

endpackage

@@ sv/pf_if.sv @@
// ----------------------------------------------------------------------------
// pf_in_if / pf_out_if
// Valid/ready channels carrying input values and factor results.
// ----------------------------------------------------------------------------
interface pf_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pf_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] prime_factor;
  logic [4:0]  exponent;
  logic        last;
  modport source (output valid, output prime_factor, output exponent, output last,
                  input ready);
  modport sink   (input valid, input prime_factor, input exponent, input last,
                  output ready);
endinterface

@@ sv/pf_div.sv @@
// ----------------------------------------------------------------------------
// pf_div
// Restoring divider: one quotient bit a cycle, done raised when the last
// quotient bit has been shifted in.
// ----------------------------------------------------------------------------
module pf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pf_pkg::VALUE_W-1:0] dividend,
  input  logic [pf_pkg::DIV_W-1:0]   divisor,
  output logic                       done,
  output logic [pf_pkg::VALUE_W-1:0] quotient,
  output logic [pf_pkg::DIV_W:0]     remainder
);
  import pf_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_W-1:0]   dsr;
  logic [DIV_W:0]     shifted;
  logic               ge;

  // shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {remainder[DIV_W-1:0], quotient[VALUE_W-1]};
    ge      = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= ge ? (shifted - {1'b0, dsr}) : shifted;
      quotient  <= {quotient[VALUE_W-2:0], ge};
    end
  end

endmodule

@@ sv/prime_factorizer.sv @@
// ----------------------------------------------------------------------------
// prime_factorizer
// Trial division by 2, 3 and then candidates 6k-1 / 6k+1, sharing one divider.
// ----------------------------------------------------------------------------
// Each candidate divisor tried is squared, compared and then divided; each further
// division by a factor runs the divider again, and each result takes an emit step; up to
// roughly 15500 candidates for a large prime input. One item at a time; ready only when idle.
// Results leave through an output register; a stalled result holds the sequencer.
// Synchronous active-high reset returns the sequencer to idle, no result valid.
// ----------------------------------------------------------------------------
module prime_factorizer (
  input  logic      clk,
  input  logic      rst,
  pf_in_if.sink     req,
  pf_out_if.source  rsp
);
  import pf_pkg::*;

  pf_state_t            state, state_next;
  logic [VALUE_W-1:0]   n;
  logic [DIV_W-1:0]     d;
  logic                 step4;
  logic [EXP_W-1:0]     e;
  logic [2*DIV_W-1:0]   sq;
  logic                 fin;
  logic [VALUE_W-1:0]   pend_f;
  logic [EXP_W-1:0]     pend_e;
  logic                 pend_l;
  logic                 out_valid;
  logic                 slot_free;
  logic                 div_start;
  logic                 div_done;
  logic [VALUE_W-1:0]   div_in;
  logic [VALUE_W-1:0]   div_q;
  logic [DIV_W:0]       div_r;

  // a repeated division carries on from the fresh quotient
  assign div_in = (state == ST_DIV) ? div_q : n;

  pf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_in),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;

  // next state and divider start
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: if (req.valid) state_next = (req.value <= VALUE_W'(1)) ? ST_EMIT : ST_SQ;
      ST_SQ:   state_next = ST_CHK;
      ST_CHK: begin
        if (sq > {1'b0, n}) begin
          state_next = (n > VALUE_W'(1)) ? ST_EMIT : ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_r == '0) begin
            div_start = 1'b1;
          end else if (e != '0) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SQ;
          end
        end
      end
      ST_EMIT: if (slot_free) state_next = fin ? ST_IDLE : ST_SQ;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n      <= req.value;
        d      <= DIV_W'(2);
        step4  <= 1'b0;
        e      <= '0;
        pend_f <= req.value;
        pend_e <= '0;
        pend_l <= 1'b1;
        fin    <= 1'b1;
      end
      ST_SQ: sq <= d * d;
      ST_CHK: begin
        pend_f <= n;
        pend_e <= EXP_W'(1);
        pend_l <= 1'b1;
        fin    <= 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_r == '0) begin
            n <= div_q;
            e <= e + 1'b1;
          end else begin
            pend_f <= VALUE_W'(d);
            pend_e <= e;
            pend_l <= (n == VALUE_W'(1));
            fin    <= (n == VALUE_W'(1));
            e      <= '0;
            // candidates 2, 3, 5, then alternate +2 / +4
            if (d < DIV_W'(5)) begin
              d <= (d == DIV_W'(2)) ? DIV_W'(3) : DIV_W'(5);
            end else begin
              d     <= step4 ? d + DIV_W'(4) : d + DIV_W'(2);
              step4 <= !step4;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      rsp.prime_factor <= pend_f;
      rsp.exponent     <= pend_e;
      rsp.last         <= pend_l;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the prime factoriser: values go in on one channel, each is
// factorised here by plain trial division, and the (prime, exponent, last)
// items that come back are checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pf_pkg::*;

  localparam int  LIMIT_CYCLES = 8_000_000;
  localparam int  SETTLE       = 200;

  typedef struct packed {
    logic [VALUE_W-1:0] factor;
    logic [EXP_W-1:0]   power;
    logic               last;
  } factor_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pf_in_if  req_ch ();
  pf_out_if rsp_ch ();

  prime_factorizer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #4 clk = ~clk;

  factor_item_t pending_factors[$];
  int           mismatches   = 0;
  int           values_sent  = 0;
  int           factors_seen = 0;
  int           cycle_count  = 0;
  bit           calm;

  int small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                           53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
  int big_primes[6]    = '{65521, 65537, 65539, 1000003, 257, 32749};

  // Append one expected factor item
  task automatic book_factor(input factor_item_t item);
    pending_factors.insert(pending_factors.size(), item);
  endtask

  // Split a value into its factor items, smallest prime first
  task automatic predict_factors(input logic [VALUE_W-1:0] value);
    longint       n;
    longint       d;
    int           e;
    factor_item_t item;
    n = value;
    if (n <= 1) begin
      item = '{factor: value, power: '0, last: 1'b1};
      book_factor(item);
      return;
    end
    d = 2;
    while (d * d <= n) begin
      e = 0;
      while (n % d == 0) begin
        n = n / d;
        e++;
      end
      if (e != 0) begin
        item = '{factor: d[VALUE_W-1:0], power: e[EXP_W-1:0], last: 1'b0};
        book_factor(item);
      end
      d = (d == 2) ? 3 : d + 2;
    end
    if (n > 1) begin
      item = '{factor: n[VALUE_W-1:0], power: EXP_W'(1), last: 1'b0};
      book_factor(item);
    end
    pending_factors[pending_factors.size()-1].last = 1'b1;
  endtask

  task automatic report(input string what, input longint want, input longint got);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s expected %0d got %0d", cycle_count, what, want,
             got);
  endtask

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Send one value and book its expected factors on acceptance
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    req_ch.value <= value;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predict_factors(value);
    values_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Product of a few stored primes, kept inside 31 bits
  function automatic logic [VALUE_W-1:0] smooth_value(input bit with_big);
    longint n;
    longint p;
    int     k;
    n = 1;
    k = $urandom_range(1, 9);
    repeat (k) begin
      p = small_primes[$urandom_range(0, 24)];
      if (n * p < 64'h8000_0000) n = n * p;
    end
    if (with_big) begin
      p = big_primes[$urandom_range(0, 5)];
      if (n * p < 64'h8000_0000) n = n * p;
    end
    return n[VALUE_W-1:0];
  endfunction

  // Extremes, the one and zero cases, a large prime left over
  task automatic test_edges();
    send_value(31'd1);
    send_value(31'd0);
    send_value(31'd2);
    send_value(31'd65535);
    send_value(31'd65536);
    send_value(31'd65521);
    send_value(31'd65537);
    send_value(31'd65537 * 31'd3);
    send_value(31'd1000003 * 31'd2);
    send_value(31'h4000_0000);
    send_value(31'd2147483646);
    send_value(31'd2147395600);
    send_value(31'd223092870);
    send_value(31'h5555_5555 & 31'h000f_ffff);
    send_value(31'd2147483647);
  endtask

  // The sender holds off until every pending factor is back
  task automatic test_hold_off();
    send_value(31'd360);
    send_value(31'd97 * 31'd97 * 31'd89);
    wait_drained();
    send_value(31'd1024);
  endtask

  // Random mix: smooth products, products with a big prime, narrow noise, three times a power of two
  task automatic test_random();
    int                 r;
    int                 w;
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < 100; i++) begin
      if (i % 30 == 0) calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) v = smooth_value(1'b0);
      else if (r < 75) v = smooth_value(1'b1);
      else if (r < 95) begin
        w = $urandom_range(1, 20);
        v = VALUE_W'($urandom() & ((32'd1 << w) - 32'd1));
      end else v = (31'h4000_0000 >> $urandom_range(1, 10)) * 31'd3;
      send_value(v);
    end
    calm = 1'b0;
  endtask

  // Result side stalls at random
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  // Check each factor item against the oldest prediction
  always @(posedge clk) begin
    factor_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      factors_seen++;
      if (pending_factors.size() == 0) begin
        report("unexpected item, factor", -1, rsp_ch.prime_factor);
      end else begin
        want = pending_factors.pop_front();
        if (rsp_ch.prime_factor !== want.factor)
          report("prime_factor", want.factor, rsp_ch.prime_factor);
        if (rsp_ch.exponent !== want.power)
          report("exponent", want.power, rsp_ch.exponent);
        if (rsp_ch.last !== want.last)
          report("last", want.last, rsp_ch.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("** prime_factorizer: FAILED **");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.value = '0;
    calm         = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_hold_off();
    test_random();
    wait_drained();
    $display("Covered %0d values (zero, one, powers of two, large prime, smooth and",
             values_sent);
    $display("big-prime products, narrow noise) giving %0d factor items", factors_seen);
    if (mismatches == 0 && pending_factors.size() == 0) begin
      $display("** prime_factorizer: PASSED **");
    end else begin
      $display("** prime_factorizer: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pf_pkg.sv
sv/pf_if.sv
sv/pf_div.sv
sv/prime_factorizer.sv
bench/tb_top.sv
